/* hw/rtl/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants for the circle collision test and resolve block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccr_pkg;

  // fixed point format and push-out margin of 0.1 pixel
  localparam int FRAC_BITS = 8;
  localparam int MARGIN_Q  = ((1 << FRAC_BITS) + 5) / 10;

  // configuration
  localparam logic       REG_PPU   = 1'b0;
  localparam logic [10:0] PPU_RESET = 11'd100;

  // operation codes
  localparam logic OP_CIRCLE = 1'b0;
  localparam logic OP_BOX    = 1'b1;

  // datapath widths
  localparam int DX_W   = 26;  // separation component
  localparam int RCH_W  = 29;  // combined reach
  localparam int SQ_W   = 54;  // four times squared length
  localparam int DIST_W = 27;  // rounded distance
  localparam int DEN_W  = 28;  // distance times scale
  localparam int OV_W   = 31;  // signed overlap
  localparam int NUM_W  = 57;  // rounded dividend magnitude
  localparam int Q_W    = 25;  // quotient bits before saturation

  localparam logic [23:0] SAT_POS = 24'h7fffff;
  localparam logic [23:0] SAT_NEG = 24'h800000;
  localparam logic [Q_W-1:0] LIM_POS = 25'd8388607;
  localparam logic [Q_W-1:0] LIM_NEG = 25'd8388608;

  // one collision pair
  typedef struct packed {
    logic               op;
    logic signed [23:0] circle_x;
    logic signed [23:0] circle_y;
    logic        [15:0] circle_radius;
    logic signed [23:0] other_x;
    logic signed [23:0] other_y;
    logic        [15:0] other_radius;
    logic        [15:0] box_width;
    logic        [15:0] box_height;
  } pair_t;

  // geometry that rides along the square root
  typedef struct packed {
    logic                   hit;
    logic                   op;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic       [RCH_W-1:0] reach;
  } side_t;

  // one rounded division job
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             zero;
    logic             flag;
  } div_job_t;

  // one result item
  typedef struct packed {
    logic        hit;
    logic [23:0] corr_x;
    logic [23:0] corr_y;
  } result_t;

endpackage

/* hw/rtl/ccr_front.sv */
// ----------------------------------------------------------------------------
// ccr_front
// Scales radii, forms the separation vector and reach, squares them and
// decides the hit flag. Four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_front import ccr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  pair_t           in_pair,
  input  logic [10:0]     ppu,
  output logic            out_valid,
  output logic [SQ_W-1:0] out_sq,
  output side_t           out_side
);

  // stage 1: scaled radii and sizes
  logic               v1, op1;
  logic signed [23:0] ax1, ay1, bx1, by1;
  logic        [26:0] ra1, rb1, hh1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= in_pair.op;
      ax1 <= in_pair.circle_x;
      ay1 <= in_pair.circle_y;
      bx1 <= in_pair.other_x;
      by1 <= in_pair.other_y;
      ra1 <= in_pair.circle_radius * ppu;
      rb1 <= ((in_pair.op == OP_BOX) ? in_pair.box_width : in_pair.other_radius) * ppu;
      hh1 <= in_pair.box_height * ppu;
    end
  end

  // stage 2: separation and reach, box test at doubled scale
  logic signed [28:0] cx2, cy2, bx2, by2, hw_s, hh_s;
  logic signed [28:0] lox, hix, loy, hiy, clx, cly, dxb, dyb, dxc, dyc;
  logic               v2, op2;
  logic signed [DX_W-1:0] dx2, dy2;
  logic [RCH_W-1:0]   reach2;

  always_comb begin
    cx2  = {{4{ax1[23]}}, ax1, 1'b0};
    cy2  = {{4{ay1[23]}}, ay1, 1'b0};
    bx2  = {{4{bx1[23]}}, bx1, 1'b0};
    by2  = {{4{by1[23]}}, by1, 1'b0};
    hw_s = {2'b00, rb1};
    hh_s = {2'b00, hh1};
    lox  = bx2 - hw_s;
    hix  = bx2 + hw_s;
    loy  = by2 - hh_s;
    hiy  = by2 + hh_s;
    clx  = (cx2 < lox) ? lox : ((cx2 > hix) ? hix : cx2);
    cly  = (cy2 < loy) ? loy : ((cy2 > hiy) ? hiy : cy2);
    dxb  = cx2 - clx;
    dyb  = cy2 - cly;
    dxc  = {{5{ax1[23]}}, ax1} - {{5{bx1[23]}}, bx1};
    dyc  = {{5{ay1[23]}}, ay1} - {{5{by1[23]}}, by1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= op1;
      if (op1 == OP_BOX) begin
        dx2    <= dxb[DX_W-1:0];
        dy2    <= dyb[DX_W-1:0];
        reach2 <= {1'b0, ra1, 1'b0};
      end else begin
        dx2    <= dxc[DX_W-1:0];
        dy2    <= dyc[DX_W-1:0];
        reach2 <= {2'b00, ra1} + {2'b00, rb1};
      end
    end
  end

  // stage 3: squares
  logic                   v3, op3;
  logic signed [DX_W-1:0] dx3, dy3;
  logic [RCH_W-1:0]       reach3;
  logic signed [2*DX_W-1:0] sqx3, sqy3;
  logic [2*RCH_W-1:0]     rsq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3    <= op2;
      dx3    <= dx2;
      dy3    <= dy2;
      reach3 <= reach2;
      sqx3   <= dx2 * dx2;
      sqy3   <= dy2 * dy2;
      rsq3   <= reach2 * reach2;
    end
  end

  // stage 4: squared length and hit compare
  logic [2*DX_W-1:0] d2;
  assign d2 = $unsigned(sqx3) + $unsigned(sqy3);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sq         <= {d2, 2'b00};
      out_side.hit   <= ({6'd0, d2} <= rsq3);
      out_side.op    <= op3;
      out_side.dx    <= dx3;
      out_side.dy    <= dy3;
      out_side.reach <= reach3;
    end
  end

endmodule

/* hw/rtl/ccr_sqrt.sv */
// ----------------------------------------------------------------------------
// ccr_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_sqrt import ccr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [SQ_W-1:0] in_sq,
  input  side_t           in_side,
  output logic            out_valid,
  output logic [SQ_W-1:0] out_root,
  output side_t           out_side
);

  localparam int STEPS = SQ_W / 2;

  logic            vs   [0:STEPS];
  logic [SQ_W-1:0] rem  [0:STEPS];
  logic [SQ_W-1:0] root [0:STEPS];
  side_t           sd   [0:STEPS];

  assign vs[0]   = in_valid;
  assign rem[0]  = in_sq;
  assign root[0] = '0;
  assign sd[0]   = in_side;

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (STEPS - 1 - j));
    logic [SQ_W-1:0] trial;
    assign trial = root[j] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else if (en) begin
        vs[j+1] <= vs[j];
      end
    end

    // one digit of the root per stage
    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1] <= sd[j];
        if (rem[j] >= trial) begin
          rem[j+1]  <= rem[j] - trial;
          root[j+1] <= (root[j] >> 1) + BIT;
        end else begin
          rem[j+1]  <= rem[j];
          root[j+1] <= root[j] >> 1;
        end
      end
    end
  end

  assign out_valid = vs[STEPS];
  assign out_root  = root[STEPS];
  assign out_side  = sd[STEPS];

endmodule

/* hw/rtl/ccr_scale.sv */
// ----------------------------------------------------------------------------
// ccr_scale
// Rounds the distance, forms the overlap and the two rounded division jobs.
// Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_scale import ccr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [SQ_W-1:0] in_root,
  input  side_t           in_side,
  output logic            out_valid,
  output div_job_t        out_x,
  output div_job_t        out_y
);

  // stage 1: distance, overlap, divisor
  logic [DIST_W:0]     r_inc;
  logic [DIST_W-1:0]   dist_rnd;
  logic signed [OV_W-1:0] ov_c;
  logic                v1, hit1, zero1;
  logic signed [DX_W-1:0] dx1, dy1;
  logic signed [OV_W-1:0] ov1;
  logic [DEN_W-1:0]    den1;

  always_comb begin
    r_inc    = in_root[DIST_W:0] + (DIST_W+1)'(1);
    dist_rnd = r_inc[DIST_W:1];
    ov_c     = $signed({2'b00, in_side.reach}) - $signed({4'd0, dist_rnd})
             + ((in_side.op == OP_BOX) ? OV_W'(2 * MARGIN_Q) : OV_W'(MARGIN_Q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit1  <= in_side.hit;
      zero1 <= (dist_rnd == '0);
      dx1   <= in_side.dx;
      dy1   <= in_side.dy;
      ov1   <= ov_c;
      den1  <= (in_side.op == OP_BOX) ? {dist_rnd, 1'b0} : {1'b0, dist_rnd};
    end
  end

  // stage 2: component times overlap
  logic                   v2, hit2, zero2;
  logic signed [NUM_W-1:0] px2, py2;
  logic [DEN_W-1:0]       den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit2  <= hit1;
      zero2 <= zero1;
      den2  <= den1;
      px2   <= dx1 * ov1;
      py2   <= dy1 * ov1;
    end
  end

  // stage 3: magnitude plus half divisor for rounding away from zero
  logic [NUM_W-1:0] mx, my, half;

  always_comb begin
    mx   = px2[NUM_W-1] ? NUM_W'(-px2) : NUM_W'(px2);
    my   = py2[NUM_W-1] ? NUM_W'(-py2) : NUM_W'(py2);
    half = NUM_W'(den2 >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x.num  <= mx + half;
      out_x.den  <= den2;
      out_x.neg  <= px2[NUM_W-1];
      out_x.zero <= zero2;
      out_x.flag <= hit2;
      out_y.num  <= my + half;
      out_y.den  <= den2;
      out_y.neg  <= py2[NUM_W-1];
      out_y.zero <= zero2;
      out_y.flag <= hit2;
    end
  end

endmodule

/* hw/rtl/ccr_div.sv */
// ----------------------------------------------------------------------------
// ccr_div
// Pipelined restoring divider with overflow check and 24-bit saturation.
// One quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_div import ccr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  div_job_t    in_job,
  output logic        out_valid,
  output logic        out_flag,
  output logic [23:0] out_value
);

  // per-stage job state
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    logic             ovf;
    logic             neg;
    logic             zero;
    logic             flag;
  } step_t;

  logic  vs [0:Q_W];
  step_t st [0:Q_W];

  // first stage: quotient would not fit in the kept bits
  logic [NUM_W:0] lim;
  assign lim = {1'b0, in_job.den, {Q_W{1'b0}}} << (NUM_W + 1 - DEN_W - Q_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem  <= in_job.num;
      st[0].den  <= in_job.den;
      st[0].quo  <= '0;
      st[0].ovf  <= ({1'b0, in_job.num} >= (lim >> (NUM_W + 1 - DEN_W - Q_W)));
      st[0].neg  <= in_job.neg;
      st[0].zero <= in_job.zero;
      st[0].flag <= in_job.flag;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int SH = Q_W - 1 - j;
    logic [NUM_W-1:0] sub;
    step_t            st_next;
    assign sub = NUM_W'(st[j].den) << SH;

    always_comb begin
      st_next = st[j];
      if (st[j].rem >= sub) begin
        st_next.rem     = st[j].rem - sub;
        st_next.quo[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else if (en) begin
        vs[j+1] <= vs[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j+1] <= st_next;
      end
    end
  end

  // final stage: sign and saturation
  logic [23:0] val;

  always_comb begin
    if (st[Q_W].zero) begin
      val = '0;
    end else if (st[Q_W].neg) begin
      if (st[Q_W].ovf || (st[Q_W].quo > LIM_NEG)) begin
        val = SAT_NEG;
      end else begin
        val = 24'(~st[Q_W].quo + Q_W'(1));
      end
    end else begin
      if (st[Q_W].ovf || (st[Q_W].quo > LIM_POS)) begin
        val = SAT_POS;
      end else begin
        val = st[Q_W].quo[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flag  <= st[Q_W].flag;
      out_value <= val;
    end
  end

endmodule

/* hw/rtl/circle_collision_test_and_resolve.sv */
// ----------------------------------------------------------------------------
// circle_collision_test_and_resolve
// Circle against circle or box collision test with push-out correction.
// ----------------------------------------------------------------------------
//
//   channel  | dir | fields (lowest bit up)
//   ---------+-----+--------------------------------------------------------
//   s_axis   | in  | tdata: circle_x, circle_y, circle_radius, other_x,
//            |     |        other_y, other_radius, box_width, box_height
//            |     | tuser: opcode
//   m_axis   | out | tdata: correction_x, correction_y; tuser: hit
//   apb      | in  | reg 0 at 0x0: unit scale in pixels (11 bits)
//
// one item per cycle while the output buffer has room; an item passes the
// front, 27-stage square root, scaling and 27-stage divider before m_tvalid.
// synchronous reset clears all valid bits; the unit scale resets to 100.
// a stalled output holds the pipe only once the two-entry output buffer is
// full, so input is still taken while one result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_collision_test_and_resolve import ccr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // circle_x, circle_y, circle_radius, other_x,
                                  // other_y, other_radius, box_width, box_height
  input  logic         s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,   // correction_x, correction_y
  output logic         m_tuser,   // hit
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // configuration register
  logic [10:0] ppu;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppu <= PPU_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PPU)) begin
      ppu <= pwdata[10:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PPU) ? {21'd0, ppu} : 32'd0;

  // pipe advances while the output buffer has room
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign s_tready = en;

  pair_t in_pair;
  always_comb begin
    in_pair.op            = s_tuser;
    in_pair.circle_x      = s_tdata[23:0];
    in_pair.circle_y      = s_tdata[47:24];
    in_pair.circle_radius = s_tdata[63:48];
    in_pair.other_x       = s_tdata[87:64];
    in_pair.other_y       = s_tdata[111:88];
    in_pair.other_radius  = s_tdata[127:112];
    in_pair.box_width     = s_tdata[143:128];
    in_pair.box_height    = s_tdata[159:144];
  end

  // front: geometry and hit
  logic            f_valid;
  logic [SQ_W-1:0] f_sq;
  side_t           f_side;

  ccr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid && s_tready),
    .in_pair   (in_pair),
    .ppu       (ppu),
    .out_valid (f_valid),
    .out_sq    (f_sq),
    .out_side  (f_side)
  );

  // distance
  logic            q_valid;
  logic [SQ_W-1:0] q_root;
  side_t           q_side;

  ccr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_sq     (f_sq),
    .in_side   (f_side),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_side  (q_side)
  );

  // overlap and division jobs
  logic     c_valid;
  div_job_t c_x, c_y;

  ccr_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .in_root   (q_root),
    .in_side   (q_side),
    .out_valid (c_valid),
    .out_x     (c_x),
    .out_y     (c_y)
  );

  // one divider per component
  logic        dx_valid, dy_valid, dx_flag, dy_flag;
  logic [23:0] dx_val, dy_val;

  ccr_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_job    (c_x),
    .out_valid (dx_valid),
    .out_flag  (dx_flag),
    .out_value (dx_val)
  );

  ccr_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_job    (c_y),
    .out_valid (dy_valid),
    .out_flag  (dy_flag),
    .out_value (dy_val)
  );

  // output register with skid entry
  result_t pipe_res, out_res, skid_res;
  assign pipe_res.hit    = dx_flag;
  assign pipe_res.corr_x = dx_val;
  assign pipe_res.corr_y = dy_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (dx_valid) begin
      if (!m_tvalid || m_tready) begin
        out_res  <= pipe_res;
        m_tvalid <= 1'b1;
      end else begin
        skid_res   <= pipe_res;
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {out_res.corr_y, out_res.corr_x};
  assign m_tuser = out_res.hit;

  // both dividers run in lock step
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    dx_valid == dy_valid)
    else $error("divider valid bits differ");

  a_hit_match: assert property (@(posedge clk) disable iff (rst)
    dx_valid |-> (dx_flag == dy_flag))
    else $error("hit flag differs between dividers");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held without an output item");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> (skid_valid && $stable(skid_res)))
    else $error("skid entry lost while output stalled");

endmodule

/* tb/tb_circle_collision_test_and_resolve.sv */
// ----------------------------------------------------------------------------
// tb_circle_collision_test_and_resolve
// Self-checking bench: directed and random collision pairs are streamed in
// under varying backpressure and each result is checked against an internal
// fixed point predictor, across several unit scale settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circle_collision_test_and_resolve;
  import ccr_pkg::*;

  localparam int LATENCY = 62;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;   // circle_x, circle_y, circle_radius, other_x,
                           // other_y, other_radius, box_width, box_height
  logic         s_tuser;   // opcode
  logic         m_tvalid;
  logic         m_tready;
  logic [47:0]  m_tdata;   // correction_x, correction_y
  logic         m_tuser;   // hit
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  circle_collision_test_and_resolve u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pair_t   pair_q[$];
  result_t result_q[$];
  logic [10:0] ppu_model;
  int      errors;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_cycles;
  logic    hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // integer square root, bitwise
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rounded division with ties away from zero, then 24-bit saturation
  function automatic logic [23:0] scaled_push(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    if (num < 0) q = -q;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[23:0];
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // collision test and push-out prediction
  function automatic result_t predict_push_out(input pair_t p);
    result_t r;
    longint ppu, ax, ay, ra, bx, by, dx, dy, reach, margin, sc, ov, hw, hh;
    logic [63:0] d2;
    logic [63:0] dist_rnd;
    ppu = longint'(ppu_model);
    ax = longint'(p.circle_x);
    ay = longint'(p.circle_y);
    bx = longint'(p.other_x);
    by = longint'(p.other_y);
    ra = longint'(p.circle_radius) * ppu;
    if (p.op == OP_CIRCLE) begin
      dx = ax - bx;
      dy = ay - by;
      reach = ra + longint'(p.other_radius) * ppu;
      margin = MARGIN_Q;
      sc = 1;
    end else begin
      hw = longint'(p.box_width) * ppu;
      hh = longint'(p.box_height) * ppu;
      dx = 2 * ax - clip(2 * ax, 2 * bx - hw, 2 * bx + hw);
      dy = 2 * ay - clip(2 * ay, 2 * by - hh, 2 * by + hh);
      reach = 2 * ra;
      margin = 2 * MARGIN_Q;
      sc = 2;
    end
    d2 = dx * dx + dy * dy;
    r.hit = (d2 <= 64'(reach) * 64'(reach));
    dist_rnd = (int_sqrt(d2 * 4) + 1) >> 1;
    if (dist_rnd == 0) begin
      r.corr_x = '0;
      r.corr_y = '0;
    end else begin
      ov = reach - longint'(dist_rnd) + margin;
      r.corr_x = scaled_push(dx * ov, longint'(dist_rnd) * sc);
      r.corr_y = scaled_push(dy * ov, longint'(dist_rnd) * sc);
    end
    return r;
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($signed(12'($urandom)));
      2: return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
      default: return 24'($signed(20'($urandom)));
    endcase
  endfunction

  function automatic logic [15:0] rand_size();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 255));
      2: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  // random pair, mostly near each other so hits and misses both occur
  function automatic pair_t rand_pair();
    pair_t p;
    p.op = 1'($urandom);
    p.circle_x = rand_coord();
    p.circle_y = rand_coord();
    if ($urandom_range(0, 3) != 0) begin
      p.other_x = p.circle_x + 24'($signed(14'($urandom)));
      p.other_y = p.circle_y + 24'($signed(14'($urandom)));
    end else begin
      p.other_x = rand_coord();
      p.other_y = rand_coord();
    end
    p.circle_radius = rand_size();
    p.other_radius = rand_size();
    p.box_width = rand_size();
    p.box_height = rand_size();
    return p;
  endfunction

  function automatic pair_t make_pair(input logic op, input logic [23:0] cx,
      input logic [23:0] cy, input logic [15:0] cr, input logic [23:0] ox,
      input logic [23:0] oy, input logic [15:0] orad, input logic [15:0] bw,
      input logic [15:0] bh);
    pair_t p;
    p.op = op;
    p.circle_x = cx;
    p.circle_y = cy;
    p.circle_radius = cr;
    p.other_x = ox;
    p.other_y = oy;
    p.other_radius = orad;
    p.box_width = bw;
    p.box_height = bh;
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid && s_tready) begin
        result_q.push_back(predict_push_out(pair_q.pop_front()));
      end
      if (pair_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pair_q[0].box_height, pair_q[0].box_width, pair_q[0].other_radius,
                    pair_q[0].other_y, pair_q[0].other_x, pair_q[0].circle_radius,
                    pair_q[0].circle_y, pair_q[0].circle_x};
        s_tuser <= pair_q[0].op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req) begin
      hold_cycles <= 400;
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("result with no pending expectation");
        errors = errors + 1;
      end else begin
        if (m_tuser !== result_q[0].hit) begin
          $error("hit: expected %0d actual %0d", result_q[0].hit, m_tuser);
          errors = errors + 1;
        end
        if (m_tdata[23:0] !== result_q[0].corr_x) begin
          $error("correction_x: expected %h actual %h", result_q[0].corr_x, m_tdata[23:0]);
          errors = errors + 1;
        end
        if (m_tdata[47:24] !== result_q[0].corr_y) begin
          $error("correction_y: expected %h actual %h", result_q[0].corr_y,
                 m_tdata[47:24]);
          errors = errors + 1;
        end
        void'(result_q.pop_front());
      end
    end
  end

  task automatic write_ppu(input logic [10:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_PPU, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ppu_model = v;
  endtask

  // wait until every queued pair was accepted and every result arrived
  task automatic drain();
    while (pair_q.size() > 0 || s_tvalid || result_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) pair_q.push_back(rand_pair());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    hold_req = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 82;
    ppu_model = PPU_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed pairs at reset scale
    pair_q.push_back(make_pair(OP_CIRCLE, 0, 0, 16'h0100, 0, 0, 16'h0100, 0, 0));
    pair_q.push_back(make_pair(OP_CIRCLE, 24'h000100, 0, 16'h0001, 0, 0, 16'h0001, 0, 0));
    pair_q.push_back(make_pair(OP_CIRCLE, SAT_POS, SAT_POS, 16'hffff, SAT_NEG, SAT_NEG,
                               16'hffff, 0, 0));
    pair_q.push_back(make_pair(OP_CIRCLE, SAT_NEG, SAT_POS, 0, SAT_POS, SAT_NEG, 0, 0, 0));
    pair_q.push_back(make_pair(OP_CIRCLE, 24'h001000, 24'hfff000, 16'hffff, 0, 0,
                               16'hffff, 0, 0));
    pair_q.push_back(make_pair(OP_CIRCLE, 24'h010000, 0, 16'h0080, 0, 0, 16'h0080, 0, 0));
    pair_q.push_back(make_pair(OP_BOX, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 16'h0100));
    pair_q.push_back(make_pair(OP_BOX, 24'h003200, 0, 16'h0100, 0, 0, 0, 16'h0100,
                               16'h0100));
    pair_q.push_back(make_pair(OP_BOX, 24'h010000, 24'h010000, 16'h0080, 0, 0, 0,
                               16'h0100, 16'h0100));
    pair_q.push_back(make_pair(OP_BOX, SAT_POS, SAT_NEG, 16'hffff, SAT_NEG, SAT_POS,
                               16'h1234, 16'hffff, 16'hffff));
    pair_q.push_back(make_pair(OP_BOX, SAT_NEG, SAT_NEG, 0, SAT_POS, SAT_POS, 0, 0, 0));
    pair_q.push_back(make_pair(OP_BOX, 24'h000400, 24'hfffc00, 0, 0, 0, 16'hffff, 0, 0));
    pair_q.push_back(make_pair(OP_BOX, 24'h000100, 0, 16'h0010, 24'h000100, 24'h000200,
                               0, 16'h0002, 0));
    pair_q.push_back(make_pair(OP_CIRCLE, 24'haaaaaa, 24'h555555, 16'haaaa, 24'h555555,
                               24'haaaaaa, 16'h5555, 16'haaaa, 16'h5555));
    pair_q.push_back(make_pair(OP_BOX, 24'h555555, 24'haaaaaa, 16'h5555, 24'haaaaaa,
                               24'h555555, 16'haaaa, 16'h5555, 16'haaaa));
    drain();

    // sender idles less than the receiver
    random_phase(300);

    // extremes of the scale, sender now idles more
    send_idle_pct = 82;
    recv_idle_pct = 28;
    write_ppu(11'd1);
    random_phase(150);
    write_ppu(11'd2047);
    random_phase(150);
    write_ppu(11'd0);
    random_phase(50);

    // no idling, with one long receiver hold-off to fill the pipe
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_ppu(11'd1024);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    random_phase(250);
    write_ppu(11'($urandom_range(1, 1024)));
    random_phase(150);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ccr_pkg.sv
hw/rtl/ccr_front.sv
hw/rtl/ccr_sqrt.sv
hw/rtl/ccr_scale.sv
hw/rtl/ccr_div.sv
hw/rtl/circle_collision_test_and_resolve.sv
tb/tb_circle_collision_test_and_resolve.sv
